// ----- rtl/bhq_pkg.sv -----
// Shared constants and types for the binary min-heap queue.
package bhq_pkg;

   parameter int HEAP_DEPTH_DEF = 1024;
   parameter int KEY_BITS_DEF   = 32;
   parameter int TAG_BITS_DEF   = 16;

   // Request kind carried in the request tuser bit.
   parameter logic FUNC_PUSH = 1'b0;
   parameter logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// ----- rtl/bhq_ram.sv -----
// Heap entry memory: one write port, two registered read ports.
module bhq_ram #(
   parameter int DEPTH  = bhq_pkg::HEAP_DEPTH_DEF,
   parameter int DATA_W = bhq_pkg::KEY_BITS_DEF + bhq_pkg::TAG_BITS_DEF,
   parameter int ADDR_W = $clog2(bhq_pkg::HEAP_DEPTH_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);
   import bhq_pkg::*;

   logic [DATA_W-1:0] heap_mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= heap_mem[rd_addr_a];
         rd_b_ff <= heap_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/bhq_ctrl.sv -----
// Heap sequencer: push sift-up and pop sift-down over the entry memory.
module bhq_ctrl #(
   parameter int HEAP_DEPTH = bhq_pkg::HEAP_DEPTH_DEF,
   parameter int KEY_BITS   = bhq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS   = bhq_pkg::TAG_BITS_DEF,
   parameter int ADDR_W     = $clog2(bhq_pkg::HEAP_DEPTH_DEF),
   parameter int OCC_W      = $clog2(bhq_pkg::HEAP_DEPTH_DEF + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [KEY_BITS-1:0]        req_key,
   input  logic [TAG_BITS-1:0]        req_tag,
   output logic                       res_valid,
   input  logic                       res_ready,
   output logic [KEY_BITS-1:0]        res_key,
   output logic [TAG_BITS-1:0]        res_tag,
   output bhq_pkg::status_type        res_status,
   output logic [OCC_W-1:0]           res_occ,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [KEY_BITS+TAG_BITS-1:0] wr_data,
   output logic                       rd_en,
   output logic [ADDR_W-1:0]          rd_addr_a,
   output logic [ADDR_W-1:0]          rd_addr_b,
   input  logic [KEY_BITS+TAG_BITS-1:0] rd_data_a,
   input  logic [KEY_BITS+TAG_BITS-1:0] rd_data_b
);
   import bhq_pkg::*;

   localparam int ENTRY_W = KEY_BITS + TAG_BITS;
   localparam int IDX_W   = ADDR_W + 2;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PUSH   = 8'b0000_0010,
      ST_UP     = 8'b0000_0100,
      ST_POPRD  = 8'b0000_1000,
      ST_POPCHK = 8'b0001_0000,
      ST_DOWN   = 8'b0010_0000,
      ST_FIN    = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [OCC_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [KEY_BITS-1:0]  item_key_ff, item_key_in;
   logic [TAG_BITS-1:0]  item_tag_ff, item_tag_in;
   logic [KEY_BITS-1:0]  res_key_ff, res_key_in;
   logic [TAG_BITS-1:0]  res_tag_ff, res_tag_in;
   status_type           res_status_ff, res_status_in;

   logic [ADDR_W-1:0]    parent_idx;
   logic [ADDR_W-1:0]    grand_idx;
   logic [IDX_W-1:0]     count_idx;
   logic [IDX_W-1:0]     left_idx;
   logic [IDX_W-1:0]     right_idx;
   logic                 left_ok;
   logic                 right_ok;
   logic [KEY_BITS-1:0]  left_key;
   logic [KEY_BITS-1:0]  right_key;
   logic [KEY_BITS-1:0]  parent_key;
   logic                 take_left;
   logic                 take_right;
   logic [KEY_BITS-1:0]  best_key;
   logic [ADDR_W-1:0]    child_addr;
   logic [ENTRY_W-1:0]   child_data;
   logic [IDX_W-1:0]     next_left;
   logic [IDX_W-1:0]     next_right;

   assign parent_idx = (pos_ff - ADDR_W'(1)) >> 1;
   assign grand_idx  = (parent_idx - ADDR_W'(1)) >> 1;
   assign count_idx  = IDX_W'(count_ff);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + IDX_W'(1);
   assign left_ok    = left_idx < count_idx;
   assign right_ok   = right_idx < count_idx;

   assign parent_key = rd_data_a[ENTRY_W-1:TAG_BITS];
   assign left_key   = rd_data_a[ENTRY_W-1:TAG_BITS];
   assign right_key  = rd_data_b[ENTRY_W-1:TAG_BITS];

   // Left wins ties: the right child is taken only when strictly smaller.
   assign take_left  = left_ok && ($signed(item_key_ff) > $signed(left_key));
   assign best_key   = take_left ? left_key : item_key_ff;
   assign take_right = right_ok && ($signed(best_key) > $signed(right_key));
   assign child_addr = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
   assign child_data = take_right ? rd_data_b : rd_data_a;
   assign next_left  = {1'b0, child_addr, 1'b1};
   assign next_right = next_left + IDX_W'(1);

   // The moving entry is kept in a register and the hole walks through the
   // memory, so a level's write and the next level's read never share an address.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      item_key_in   = item_key_ff;
      item_tag_in   = item_tag_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {item_key_ff, item_tag_ff};
      rd_en         = 1'b0;
      rd_addr_a     = parent_idx;
      rd_addr_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_key_in = req_key;
               item_tag_in = req_tag;
               res_key_in  = '0;
               res_tag_in  = '0;
               if (req_func == FUNC_PUSH) begin
                  if (count_ff == OCC_W'(HEAP_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESULT;
                  end else begin
                     res_status_in = STATUS_DONE;
                     pos_in        = count_ff[ADDR_W-1:0];
                     count_in      = count_ff + OCC_W'(1);
                     state_in      = ST_PUSH;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_RESULT;
                  end else begin
                     res_status_in = STATUS_DONE;
                     state_in      = ST_POPRD;
                  end
               end
            end
         end
         ST_PUSH: begin
            if (pos_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = parent_idx;
               state_in  = ST_UP;
            end
         end
         ST_UP: begin
            if ($signed(parent_key) > $signed(item_key_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data_a;
               pos_in  = parent_idx;
               if (parent_idx == '0) begin
                  state_in = ST_FIN;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr_a = grand_idx;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = ST_RESULT;
            end
         end
         ST_POPRD: begin
            rd_en     = 1'b1;
            rd_addr_a = '0;
            rd_addr_b = ADDR_W'(count_ff - OCC_W'(1));
            count_in  = count_ff - OCC_W'(1);
            state_in  = ST_POPCHK;
         end
         ST_POPCHK: begin
            res_key_in  = rd_data_a[ENTRY_W-1:TAG_BITS];
            res_tag_in  = rd_data_a[TAG_BITS-1:0];
            item_key_in = rd_data_b[ENTRY_W-1:TAG_BITS];
            item_tag_in = rd_data_b[TAG_BITS-1:0];
            pos_in      = '0;
            if (count_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               rd_en     = count_ff > OCC_W'(1);
               rd_addr_a = ADDR_W'(1);
               rd_addr_b = ADDR_W'(2);
               state_in  = ST_DOWN;
            end
         end
         ST_DOWN: begin
            if (take_left || take_right) begin
               wr_en     = 1'b1;
               wr_data   = child_data;
               pos_in    = child_addr;
               rd_en     = next_left < count_idx;
               rd_addr_a = next_left[ADDR_W-1:0];
               rd_addr_b = next_right[ADDR_W-1:0];
            end else begin
               wr_en    = 1'b1;
               state_in = ST_RESULT;
            end
         end
         ST_FIN: begin
            wr_en    = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      item_key_ff   <= item_key_in;
      item_tag_ff   <= item_tag_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_RESULT);
   assign res_key    = res_key_ff;
   assign res_tag    = res_tag_ff;
   assign res_status = res_status_ff;
   assign res_occ    = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OCC_W'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == OCC_W'($past(count_ff) + OCC_W'(1)) ||
                              count_ff == OCC_W'($past(count_ff) - OCC_W'(1))))
      else $error("entry count moved by more than one");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr_a && wr_addr != rd_addr_b))
      else $error("memory read and write hit the same entry");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_status_ff != STATUS_DONE) |->
         (res_key_ff == '0 && res_tag_ff == '0))
      else $error("failed operation returned a nonzero entry");

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
// Binary min-heap priority queue: top level with the result output register.
// A push climbs level by level from the new slot; a pop reads the root and the last entry,
// then sinks level by level unless it empties the heap; a refused push or pop goes straight to the result.
// Throughput: one operation at a time; the next request is taken only after the
// previous result has moved into the output register.
// Reset: synchronous, empties the heap; the entry memory itself is not cleared.
module binary_min_heap_queue #(
   parameter int HEAP_DEPTH = bhq_pkg::HEAP_DEPTH_DEF,
   parameter int KEY_BITS   = bhq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS   = bhq_pkg::TAG_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // key, tag
   input  logic [((KEY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // func
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_key, out_tag, occupancy
   output logic [((KEY_BITS + TAG_BITS + $clog2(HEAP_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);
   import bhq_pkg::*;

   localparam int ADDR_W  = $clog2(HEAP_DEPTH);
   localparam int OCC_W   = $clog2(HEAP_DEPTH + 1);
   localparam int ENTRY_W = KEY_BITS + TAG_BITS;
   localparam int RSP_W   = ((KEY_BITS + TAG_BITS + OCC_W + 7) / 8) * 8;

   logic                res_valid;
   logic                res_ready;
   logic [KEY_BITS-1:0] res_key;
   logic [TAG_BITS-1:0] res_tag;
   status_type          res_status;
   logic [OCC_W-1:0]    res_occ;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr_a;
   logic [ADDR_W-1:0]   rd_addr_b;
   logic [ENTRY_W-1:0]  rd_data_a;
   logic [ENTRY_W-1:0]  rd_data_b;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;
   status_type          rsp_status_ff, rsp_status_in;

   bhq_ctrl #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .TAG_BITS   (TAG_BITS),
      .ADDR_W     (ADDR_W),
      .OCC_W      (OCC_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser[0]),
      .req_key    (req_tdata[KEY_BITS-1:0]),
      .req_tag    (req_tdata[ENTRY_W-1:KEY_BITS]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_key    (res_key),
      .res_tag    (res_tag),
      .res_status (res_status),
      .res_occ    (res_occ),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b)
   );

   bhq_ram #(
      .DEPTH  (HEAP_DEPTH),
      .DATA_W (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // The output register takes a new result whenever it is empty or its
   // current result is transferred in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_key_in    = res_key;
            rsp_tag_in    = res_tag;
            rsp_occ_in    = res_occ;
            rsp_status_in = res_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_occ_ff, rsp_tag_ff, rsp_key_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the binary min-heap queue, checked against a behavioral heap.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bhq_pkg::*;

   localparam int HEAP_N = HEAP_DEPTH_DEF;
   localparam int KEY_W  = KEY_BITS_DEF;
   localparam int TAG_W  = TAG_BITS_DEF;
   localparam int OCC_W  = $clog2(HEAP_N + 1);
   localparam int REQ_W  = ((KEY_W + TAG_W + 7) / 8) * 8;
   localparam int RSP_W  = ((KEY_W + TAG_W + OCC_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 50;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
      status_type              status;
      logic [OCC_W-1:0]        occ;
   } heap_reply_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // key, tag
   logic [REQ_W-1:0] req_tdata = '0;
   // func
   logic [0:0]       req_tuser = FUNC_PUSH;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // out_key, out_tag, occupancy
   logic [RSP_W-1:0] rsp_tdata;
   // status
   logic [1:0]       rsp_tuser;

   // Behavioral copy of the heap, updated at each request transfer.
   logic signed [KEY_W-1:0] heap_key [HEAP_N];
   logic [TAG_W-1:0]        heap_tag [HEAP_N];
   int                      heap_size = 0;
   heap_reply_type          queued_replies [$];

   int  cycles = 0;
   int  mismatches = 0;
   int  replies_checked = 0;
   int  pushes_done = 0, full_pushes = 0, pops_done = 0, empty_pops = 0, peak_occ = 0;
   bit  src_steady = 1'b0;
   bit  sink_steady = 1'b0;
   int  hold_request = 0;
   int  hold_count = 0;
   int  sink_gap = 0;

   binary_min_heap_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d replies outstanding.",
                  cycles, queued_replies.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void swap_slots(int a, int b);
      logic signed [KEY_W-1:0] k;
      logic [TAG_W-1:0]        t;
      k = heap_key[a];
      t = heap_tag[a];
      heap_key[a] = heap_key[b];
      heap_tag[a] = heap_tag[b];
      heap_key[b] = k;
      heap_tag[b] = t;
   endfunction

   function automatic heap_reply_type heap_apply(logic func, logic signed [KEY_W-1:0] key,
                                                 logic [TAG_W-1:0] tag);
      heap_reply_type res;
      int pos, parent, child, best;
      res.key = '0;
      res.tag = '0;
      res.status = STATUS_DONE;
      if (func == FUNC_PUSH) begin
         if (heap_size >= HEAP_N) begin
            res.status = STATUS_FULL;
            full_pushes++;
         end else begin
            pos = heap_size;
            heap_key[pos] = key;
            heap_tag[pos] = tag;
            heap_size++;
            pushes_done++;
            // Climb while the parent is strictly greater.
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (heap_key[parent] <= heap_key[pos]) break;
               swap_slots(parent, pos);
               pos = parent;
            end
         end
      end else begin
         if (heap_size == 0) begin
            res.status = STATUS_EMPTY;
            empty_pops++;
         end else begin
            res.key = heap_key[0];
            res.tag = heap_tag[0];
            heap_size--;
            pops_done++;
            if (heap_size > 0) begin
               heap_key[0] = heap_key[heap_size];
               heap_tag[0] = heap_tag[heap_size];
               pos = 0;
               // Sink toward the smaller child; the left one wins a tie.
               forever begin
                  child = 2 * pos + 1;
                  best = pos;
                  if (child < heap_size && heap_key[best] > heap_key[child]) best = child;
                  if (child + 1 < heap_size && heap_key[best] > heap_key[child + 1])
                     best = child + 1;
                  if (best == pos) break;
                  swap_slots(pos, best);
                  pos = best;
               end
            end
         end
      end
      if (heap_size > peak_occ) peak_occ = heap_size;
      res.occ = OCC_W'(heap_size);
      return res;
   endfunction

   function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("Mismatch at reply %0d: %s expected %0h, got %0h",
                  replies_checked, what, want, got);
   endfunction

   // Result checker: each reply transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_checked++;
         if (queued_replies.size() == 0) begin
            note_mismatch("unexpected reply, data", '0, 64'(rsp_tdata));
         end else begin
            want = queued_replies.pop_front();
            if (rsp_tdata[KEY_W-1:0] !== want.key)
               note_mismatch("out_key", 64'(want.key), 64'(rsp_tdata[KEY_W-1:0]));
            if (rsp_tdata[KEY_W+TAG_W-1:KEY_W] !== want.tag)
               note_mismatch("out_tag", 64'(want.tag), 64'(rsp_tdata[KEY_W+TAG_W-1:KEY_W]));
            if (rsp_tdata[KEY_W+TAG_W+OCC_W-1:KEY_W+TAG_W] !== want.occ)
               note_mismatch("occupancy", 64'(want.occ),
                             64'(rsp_tdata[KEY_W+TAG_W+OCC_W-1:KEY_W+TAG_W]));
            if (rsp_tdata[RSP_W-1:KEY_W+TAG_W+OCC_W] !== '0)
               note_mismatch("padding", '0, 64'(rsp_tdata[RSP_W-1:KEY_W+TAG_W+OCC_W]));
            if (rsp_tuser !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp_tuser));
         end
      end
   end

   // Reply side: random stalls, plus a long hold-off counted here when requested.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_tready = 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
         if (!sink_steady && $urandom_range(0, 3) == 0) sink_gap = idle_gap();
      end
   end

   task automatic send_op(logic func, logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      int gap;
      gap = src_steady ? 0 : idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = REQ_W'({tag, key});
      do @(posedge clock); while (!req_tready);
      queued_replies.push_back(heap_apply(func, key, tag));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (queued_replies.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key(int mode);
      logic signed [KEY_W-1:0] k;
      case (mode)
         1: k = $signed(KEY_W'($urandom_range(0, 7))) - 4;
         2: begin
            case ($urandom_range(0, 5))
               0: k = {1'b1, {(KEY_W-1){1'b0}}};
               1: k = {1'b0, {(KEY_W-1){1'b1}}};
               2: k = '0;
               3: k = '1;
               4: k = {1'b1, {(KEY_W-2){1'b0}}, 1'b1};
               default: k = {1'b0, {(KEY_W-2){1'b1}}, 1'b0};
            endcase
         end
         default: k = KEY_W'($urandom());
      endcase
      return k;
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
   endfunction

   task automatic test_empty_pop();
      send_op(FUNC_POP, pick_key(0), pick_tag());
      send_op(FUNC_POP, '1, '1);
      wait_drained();
   endtask

   task automatic test_extremes_and_ties();
      send_op(FUNC_PUSH, {1'b0, {(KEY_W-1){1'b1}}}, '1);
      send_op(FUNC_PUSH, {1'b1, {(KEY_W-1){1'b0}}}, '0);
      send_op(FUNC_PUSH, '0, 16'h1234);
      send_op(FUNC_PUSH, '1, 16'h8001);
      send_op(FUNC_PUSH, 1, 16'h00ff);
      // Equal keys exercise the left-child preference when sinking.
      send_op(FUNC_PUSH, 5, 16'h0001);
      send_op(FUNC_PUSH, 5, 16'h0002);
      send_op(FUNC_PUSH, 5, 16'h0003);
      send_op(FUNC_PUSH, 5, 16'h0004);
      repeat (10) send_op(FUNC_POP, '0, '0);
      wait_drained();
   endtask

   // Fills the heap from whatever it holds, then pops a stretch from the full heap
   // so the moved entry sinks through every level.
   task automatic test_full_heap();
      repeat (HEAP_N - heap_size)
         send_op(FUNC_PUSH, pick_key($urandom_range(0, 3) == 0), pick_tag());
      repeat (3) send_op(FUNC_PUSH, pick_key(0), pick_tag());
      repeat (2) send_op(FUNC_POP, pick_key(0), pick_tag());
      repeat (2) send_op(FUNC_PUSH, pick_key(2), pick_tag());
      send_op(FUNC_PUSH, pick_key(0), pick_tag());
      repeat (24) send_op(FUNC_POP, pick_key(0), pick_tag());
      wait_drained();
   endtask

   task automatic test_backpressure();
      src_steady = 1'b1;
      hold_request = 400;
      repeat (40) send_op(($urandom_range(0, 3) == 0) ? FUNC_POP : FUNC_PUSH,
                          pick_key(0), pick_tag());
      src_steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_mix();
      int done_items, seg_len, push_pct, key_mode;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 120);
         if (seg_len > RANDOM_ITEMS - done_items) seg_len = RANDOM_ITEMS - done_items;
         case ($urandom_range(0, 3))
            0: push_pct = 25;
            1: push_pct = 50;
            2: push_pct = 70;
            default: push_pct = 90;
         endcase
         key_mode = ($urandom_range(0, 3) < 2) ? 0 : $urandom_range(1, 2);
         src_steady = ($urandom_range(0, 3) == 0);
         sink_steady = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            send_op(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP,
                    pick_key(key_mode), pick_tag());
            done_items++;
         end
      end
      src_steady = 1'b0;
      sink_steady = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_pop();
      test_extremes_and_ties();
      test_random_mix();
      test_full_heap();
      test_backpressure();

      repeat (30) @(posedge clock);
      $display("Checked %0d replies: %0d pushes, %0d refused on a full heap,", replies_checked,
               pushes_done, full_pushes);
      $display("%0d pops, %0d on an empty heap; peak occupancy %0d of %0d.", pops_done,
               empty_pops, peak_occ, HEAP_N);
      if (mismatches == 0 && queued_replies.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/bhq_pkg.sv
rtl/bhq_ram.sv
rtl/bhq_ctrl.sv
rtl/binary_min_heap_queue.sv
bench/tb.sv
